FILE: design/fp34_pkg.sv
// Shared types, segment coefficients and rounding helper for the |x|^0.75 pipeline.
// Used by fp34_lin and float_pow_three_quarters; depends on nothing else.
package fp34_pkg;

    typedef struct packed {
        logic [31:0] x_bits;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [30:0] y_bits;
        logic        last_out;
    } out_item_t;

    // per-item side info carried alongside the segment evaluation
    typedef struct packed {
        logic        zero;
        logic        inf;
        logic [7:0]  scale_exp;
        logic [22:0] scale_frac;
        logic        last;
    } side_t;

    typedef struct packed {
        logic [1:0]  eadd;
        logic [22:0] frac;
    } rnd_t;

    localparam int SEG_COUNT = 16;
    localparam logic [7:0] EXP_MAX = 8'hFF;
    localparam logic [7:0] SCALE_EXP_BIAS = 8'd31;

    // segment offsets (exponent 125) and slopes (exponent 126), fraction bits only
    localparam logic [22:0] OFFSET_FRAC [SEG_COUNT] = '{
        23'h02F5BA, 23'h08E2EA, 23'h0EB69B, 23'h14763F,
        23'h1A231E, 23'h1FBE5A, 23'h2548FA, 23'h2AC3E8,
        23'h302FFB, 23'h358DF2, 23'h3ADE80, 23'h402244,
        23'h4559D4, 23'h4A85B7, 23'h4FA66D, 23'h53DD93
    };

    localparam logic [22:0] SLOPE_FRAC [SEG_COUNT] = '{
        23'h3E8806, 23'h3BBE0E, 23'h392714, 23'h36BB71,
        23'h34764B, 23'h32538A, 23'h304FAD, 23'h2E67B3,
        23'h2C9902, 23'h2AE156, 23'h293EB5, 23'h27AF5E,
        23'h2631C7, 23'h24C491, 23'h236683, 23'h225006
    };

    // fraction bits of 2^(f/4)
    localparam logic [22:0] QUARTER_FRAC [4] = '{
        23'h000000, 23'h1837F0, 23'h3504F3, 23'h5744FD
    };

    // Round a 48-bit product of two 1.x mantissas to 24 bits, nearest even.
    // eadd: 1 when the top bit was set, plus 1 on mantissa overflow.
    function automatic rnd_t round48(input logic [47:0] p);
        logic [23:0] m;
        logic        g;
        logic        st;
        logic [24:0] s;
        rnd_t        r;
        if (p[47])
        begin
            m  = p[47:24];
            g  = p[23];
            st = |p[22:0];
        end
        else
        begin
            m  = p[46:23];
            g  = p[22];
            st = |p[21:0];
        end
        s = {1'b0, m} + {24'd0, g & (st | m[0])};
        if (s[24])
        begin
            r.frac = '0;
            r.eadd = {1'b0, p[47]} + 2'd1;
        end
        else
        begin
            r.frac = s[22:0];
            r.eadd = {1'b0, p[47]};
        end
        return r;
    endfunction

endpackage

FILE: design/fp34_lin.sv
// Three-stage evaluation of the linear segment m*slope + offset.
// Depends on fp34_pkg.
module fp34_lin
    import fp34_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [22:0] mant,
    input  logic [3:0]  seg,
    input  side_t       in_side,
    output logic        out_valid,
    output logic        lin_hi,      // 1: exponent 127, 0: exponent 126
    output logic [22:0] lin_frac,
    output side_t       out_side
);

    logic [2:0]  valid_reg;
    logic [47:0] prod_reg;
    logic [22:0] off1_reg, off2_reg;
    side_t       side1_reg, side2_reg, side3_reg;
    logic        ph_reg;
    logic [23:0] pm_reg;
    logic        lhi_reg;
    logic [22:0] lfrac_reg;

    rnd_t        prod_rnd;
    logic [26:0] sum_next;
    rnd_t        sum_rnd;

    assign prod_rnd = round48(prod_reg);

    // both terms exact in units of 2^-25, so the sum needs no sticky bit
    always_comb
    begin
        sum_next = (ph_reg ? {1'b0, pm_reg, 2'b00} : {2'b00, pm_reg, 1'b0})
                 + {3'd0, 1'b1, off2_reg};
        sum_rnd  = round48({sum_next[25:0], 22'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= {24'd0, 1'b1, mant} * {24'd0, 1'b1, SLOPE_FRAC[seg]};
        off1_reg  <= OFFSET_FRAC[seg];
        side1_reg <= in_side;

        ph_reg    <= prod_rnd.eadd[0];
        pm_reg    <= {1'b1, prod_rnd.frac};
        off2_reg  <= off1_reg;
        side2_reg <= side1_reg;

        lhi_reg   <= |sum_rnd.eadd;
        lfrac_reg <= sum_rnd.frac;
        side3_reg <= side2_reg;
    end

    assign out_valid = valid_reg[2];
    assign lin_hi    = lhi_reg;
    assign lin_frac  = lfrac_reg;
    assign out_side  = side3_reg;

endmodule

FILE: design/float_pow_three_quarters.sv
// Approximate |x|^0.75 on IEEE single values: segment evaluation, then exponent scaling.
// Five register stages, three in fp34_lin and then the scaling product and the result register;
// done is registered alongside the result; one transaction per cycle.
// The pipeline never stalls (busy is always low); the receiver cannot hold results off.
// Reset clears only the valid bits; payload registers are not reset.
// Depends on fp34_pkg and fp34_lin.
module float_pow_three_quarters
    import fp34_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  operand,
    output logic      done,
    output out_item_t result
);

    side_t       side_in;
    logic [9:0]  t3;
    logic [7:0]  xexp;

    logic        lin_valid;
    logic        lin_hi;
    logic [22:0] lin_frac;
    side_t       lin_side;

    logic        v4_reg, v5_reg;
    logic [47:0] p2_reg;
    logic [7:0]  eb_reg;
    side_t       side4_reg;
    out_item_t   res_reg;

    rnd_t        fin_rnd;
    logic [30:0] y_next;

    assign busy = 1'b0;
    assign xexp = operand.x_bits[30:23];

    // scale = 2^(0.75*(e-127)): t = 3e+3, exponent (t>>2)+31, fraction from t mod 4
    always_comb
    begin
        t3                 = {2'b00, xexp} * 10'd3 + 10'd3;
        side_in.zero       = (xexp == 8'd0);
        side_in.inf        = (xexp == EXP_MAX);
        side_in.scale_exp  = t3[9:2] + SCALE_EXP_BIAS;
        side_in.scale_frac = QUARTER_FRAC[t3[1:0]];
        side_in.last       = operand.last_in;
    end

    fp34_lin u_lin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .mant      (operand.x_bits[22:0]),
        .seg       (operand.x_bits[22:19]),
        .in_side   (side_in),
        .out_valid (lin_valid),
        .lin_hi    (lin_hi),
        .lin_frac  (lin_frac),
        .out_side  (lin_side)
    );

    assign fin_rnd = round48(p2_reg);

    always_comb
    begin
        if (side4_reg.zero)
            y_next = '0;
        else if (side4_reg.inf)
            y_next = {EXP_MAX, 23'd0};
        else
            y_next = {eb_reg + {6'd0, fin_rnd.eadd}, fin_rnd.frac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= lin_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg    <= {24'd0, 1'b1, lin_frac} * {24'd0, 1'b1, lin_side.scale_frac};
        eb_reg    <= lin_side.scale_exp + {7'd0, lin_hi} - 8'd1;
        side4_reg <= lin_side;

        res_reg.y_bits   <= y_next;
        res_reg.last_out <= side4_reg.last;
    end

    assign done   = v5_reg;
    assign result = res_reg;

endmodule

FILE: tb/float_pow_three_quarters_tb.sv
// Self-checking testbench for float_pow_three_quarters (|x|^0.75 on IEEE single values).
// Directed and random transactions, checked against an in-bench bit-exact predictor.
// Depends on fp34_pkg and the float_pow_three_quarters RTL.
`timescale 1ns / 100ps

module float_pow_three_quarters_tb
    import fp34_pkg::*;
();

    localparam logic [31:0] SGL_INF = 32'h7F80_0000;

    // zeros, denormals, extremes of the exponent, infinity, NaN, negatives
    localparam int N_DIRECTED = 13;
    localparam logic [31:0] DIRECTED_X [N_DIRECTED] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
        32'h0080_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'h7FFF_FFFF, 32'h3F80_0000, 32'hBF80_0000,
        32'hFFFF_FFFF
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  operand;
    logic      done;
    out_item_t result;

    in_item_t  pending_q[$];
    out_item_t pow_expect_q[$];
    int        n_sent;
    int        n_checked;
    int        n_mismatch;
    int        n_special;
    bit        stim_loaded;

    float_pow_three_quarters i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    // slopes (exponent 126) and offsets (exponent 125) of the 16 segments
    localparam logic [31:0] SLOPE_W [16] = '{
        32'h3F3E8806, 32'h3F3BBE0E, 32'h3F392714, 32'h3F36BB71,
        32'h3F34764B, 32'h3F32538A, 32'h3F304FAD, 32'h3F2E67B3,
        32'h3F2C9902, 32'h3F2AE156, 32'h3F293EB5, 32'h3F27AF5E,
        32'h3F2631C7, 32'h3F24C491, 32'h3F236683, 32'h3F225006
    };
    localparam logic [31:0] OFFSET_W [16] = '{
        32'h3E82F5BA, 32'h3E88E2EA, 32'h3E8EB69B, 32'h3E94763F,
        32'h3E9A231E, 32'h3E9FBE5A, 32'h3EA548FA, 32'h3EAAC3E8,
        32'h3EB02FFB, 32'h3EB58DF2, 32'h3EBADE80, 32'h3EC02244,
        32'h3EC559D4, 32'h3ECA85B7, 32'h3ECFA66D, 32'h3ED3DD93
    };
    localparam logic [22:0] QTR_FRAC [4] = '{
        23'h000000, 23'h1837F0, 23'h3504F3, 23'h5744FD
    };

    // normal single -> real, exact
    function automatic real sgl_to_real(input logic [31:0] s);
        logic [10:0] de;
        de = 11'(s[30:23]) - 11'd127 + 11'd1023;
        return $bitstoreal({1'b0, de, s[22:0], 29'd0});
    endfunction

    // real -> single, nearest even; operands here stay in the normal range
    function automatic logic [31:0] real_to_sgl(input real r);
        logic [63:0] d;
        logic [24:0] m;
        logic [8:0]  e;
        logic        g;
        logic        st;
        d = $realtobits(r);
        if (d[62:52] == 11'd0)
            return 32'd0;
        e  = 9'(d[62:52] - 11'd1023 + 11'd127);
        m  = {2'b01, d[51:29]};
        g  = d[28];
        st = |d[27:0];
        m  = m + 25'(g & (st | m[0]));
        if (m[24])
        begin
            e = e + 9'd1;
            m = m >> 1;
        end
        return {1'b0, e[7:0], m[22:0]};
    endfunction

    // (m*slope + offset) * scale, each step rounded to single
    function automatic out_item_t pow34_predict(input in_item_t it);
        out_item_t   o;
        logic [7:0]  ex;
        logic [3:0]  seg;
        logic [9:0]  t;
        logic [31:0] scale;
        logic [31:0] prod;
        logic [31:0] lin;
        logic [31:0] y;
        ex  = it.x_bits[30:23];
        seg = it.x_bits[22:19];
        t   = 10'd3 * 10'(ex) + 10'd3;
        scale = {1'b0, 8'(t[9:2]) + 8'd31, QTR_FRAC[t[1:0]]};
        prod = real_to_sgl(sgl_to_real({9'h07F, it.x_bits[22:0]}) * sgl_to_real(SLOPE_W[seg]));
        lin  = real_to_sgl(sgl_to_real(prod) + sgl_to_real(OFFSET_W[seg]));
        y    = real_to_sgl(sgl_to_real(lin) * sgl_to_real(scale));
        if (ex == 8'd0)
            y = 32'd0;
        else if (ex == EXP_MAX)
            y = SGL_INF;
        o.y_bits   = y[30:0];
        o.last_out = it.last_in;
        return o;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: sender idles 32 %, then 86 %, then never
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            operand <= '0;
        end
        else
        begin
            int idle_pct;
            idle_pct = (n_sent < 350) ? 32 : (n_sent < 700) ? 86 : 0;
            if (start && !busy)
            begin
                pow_expect_q.push_back(pow34_predict(operand));
                void'(pending_q.pop_front());
                n_sent++;
            end
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start   <= 1'b1;
                operand <= pending_q[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pow_expect_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result y=%h last=%b", result.y_bits,
                             result.last_out);
            end
            else
            begin
                out_item_t exp_o;
                exp_o = pow_expect_q.pop_front();
                n_checked++;
                if (exp_o.y_bits !== result.y_bits || exp_o.last_out !== result.last_out)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: transaction %0d y exp %h got %h, last exp %b got %b",
                                 n_checked, exp_o.y_bits, result.y_bits,
                                 exp_o.last_out, result.last_out);
                end
            end
        end
    end

    initial
    begin
        in_item_t it;
        rst_n       = 1'b0;
        n_sent      = 0;
        n_checked   = 0;
        n_mismatch  = 0;
        n_special   = 0;
        stim_loaded = 1'b0;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            it.x_bits  = DIRECTED_X[i];
            it.last_in = i[0];
            pending_q.push_back(it);
        end
        // one item in each segment
        for (int s = 0; s < 16; s++)
        begin
            it.x_bits  = {1'b0, 8'd127, 4'(s), 19'($urandom)};
            it.last_in = (s == 15);
            pending_q.push_back(it);
        end
        for (int k = 0; k < 1050; k++)
        begin
            it.x_bits  = $urandom;
            it.last_in = ($urandom_range(7) == 0);
            case ($urandom_range(9))
                0: it.x_bits[30:23] = 8'd0;
                1: it.x_bits[30:23] = EXP_MAX;
                2: it.x_bits[30:23] = 8'(120 + $urandom_range(15));
                default: ;
            endcase
            if (it.x_bits[30:23] == 8'd0 || it.x_bits[30:23] == EXP_MAX)
                n_special++;
            pending_q.push_back(it);
        end
        stim_loaded = 1'b1;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        while (pending_q.size() > 0 || start || pow_expect_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Checked %0d transactions over three idling phases,", n_checked);
        $display("%0d of the random ones zero, denormal, infinity or NaN.", n_special);
        if (n_mismatch == 0 && pow_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pow_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
design/fp34_pkg.sv
design/fp34_lin.sv
design/float_pow_three_quarters.sv
tb/float_pow_three_quarters_tb.sv
